FILE: hw/rtl/kwsm_pkg.sv
package kwsm_pkg;

  // table geometry
  localparam int MAX_KEYWORDS    = 16;
  localparam int MAX_KEYWORD_LEN = 32;

  // index and count widths
  localparam int KW_IDX_W   = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
  localparam int KW_CNT_W   = $clog2(MAX_KEYWORDS + 1);
  localparam int CHAR_IDX_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int LEN_W      = $clog2(MAX_KEYWORD_LEN + 1);

  // item opcodes
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_LEN  = 2'd1;
  localparam logic [1:0] OP_TEXT = 2'd2;

  typedef logic [MAX_KEYWORD_LEN-1:0][7:0] char_row_t;
  typedef logic [MAX_KEYWORD_LEN-1:0]      prefix_t;

  // result of one keyword row update
  typedef struct packed {
    prefix_t vec;
    logic    upd;
    logic    hit;
  } row_res_t;

endpackage

FILE: hw/rtl/kwsm_char_mem.sv
module kwsm_char_mem (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [kwsm_pkg::KW_IDX_W-1:0]   wr_row,
  input  logic [kwsm_pkg::CHAR_IDX_W-1:0] wr_col,
  input  logic [7:0]                      wr_data,
  input  logic [kwsm_pkg::KW_IDX_W-1:0]   rd_row,
  output kwsm_pkg::char_row_t             rd_data
);

  // one row per keyword, byte-wide writes
  kwsm_pkg::char_row_t mem_r [kwsm_pkg::MAX_KEYWORDS];
  kwsm_pkg::char_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row][wr_col] <= wr_data;
    end
    rd_data_r <= mem_r[rd_row];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/kwsm_row_unit.sv
module kwsm_row_unit (
  input  kwsm_pkg::char_row_t        row,
  input  logic [7:0]                 text_byte,
  input  logic [kwsm_pkg::LEN_W-1:0] len,
  input  kwsm_pkg::prefix_t          vec_in,
  output kwsm_pkg::row_res_t         res
);

  kwsm_pkg::prefix_t                match;
  kwsm_pkg::prefix_t                shifted;
  logic [kwsm_pkg::CHAR_IDX_W-1:0]  tail;

  // compare the text byte against every character of the row, masked by length
  always_comb begin
    for (int j = 0; j < kwsm_pkg::MAX_KEYWORD_LEN; j++) begin
      match[j] = (row[j] == text_byte) && (j < int'(len));
    end
    shifted = (vec_in << 1) | kwsm_pkg::prefix_t'(1);
    tail    = kwsm_pkg::CHAR_IDX_W'(len - 1'b1);
    res.vec = shifted & match;
    res.upd = (len != '0);
    // empty keyword always hits
    res.hit = !res.upd || res.vec[tail];
  end

endmodule

FILE: hw/rtl/multi_keyword_substring_match_core.sv
// Keyword substring detector using shift-and prefix vectors. Items with opcode
// store keyword character or store keyword length load the keyword table and
// leave busy low. A text byte keeps busy high until the rows of all A active
// keywords are compared, where A is keyword_count clamped to the table size.
// The keyword character memory has one read port and yields one keyword row
// per cycle, which the single row compare unit consumes. The memory read is
// registered; once the last row is compared and folded in, the byte closes.
// busy is high while a text byte is in work; start is taken only while busy is
// low. On a text byte with last_byte set, one result (out_found) appears in the
// first cycle in which busy is low again. It is marked by out_valid for exactly
// one cycle; the receiver cannot stall it. Prefix vectors and the found flag
// are then cleared for the next text. The user writes keyword_count through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
module multi_keyword_substring_match_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_keyword_slot,
  input  logic [4:0] in_char_position,
  input  logic [7:0] in_byte_value,
  input  logic [5:0] in_keyword_length,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic       out_found,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // control state
  logic                              state_r, state_nxt;
  logic [4:0]                        count_r;
  logic [kwsm_pkg::KW_CNT_W-1:0]     active_r, active_nxt;
  logic [kwsm_pkg::KW_CNT_W-1:0]     issue_r, issue_nxt;
  logic                              proc_v_r, proc_v_nxt;
  logic [kwsm_pkg::KW_IDX_W-1:0]     proc_idx_r, proc_idx_nxt;
  logic                              found_r, found_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_found_r, out_found_nxt;
  logic                              clear_pv;

  // item payload held during a scan
  logic [7:0]                        byte_r, byte_nxt;
  logic                              last_r, last_nxt;

  // keyword lengths and prefix vectors, one entry per slot
  logic [kwsm_pkg::LEN_W-1:0]        len_r [kwsm_pkg::MAX_KEYWORDS];
  kwsm_pkg::prefix_t                 pv_r  [kwsm_pkg::MAX_KEYWORDS];

  logic                              accept;
  logic                              char_we;
  logic                              len_we;
  logic [kwsm_pkg::KW_CNT_W-1:0]     active_eff;
  logic [kwsm_pkg::LEN_W-1:0]        len_sat;
  kwsm_pkg::char_row_t               row_data;
  kwsm_pkg::row_res_t                row_res;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // table writes outside the table are dropped
  assign char_we = accept && (in_opcode == kwsm_pkg::OP_CHAR)
                   && (int'(in_keyword_slot) < kwsm_pkg::MAX_KEYWORDS)
                   && (int'(in_char_position) < kwsm_pkg::MAX_KEYWORD_LEN);
  assign len_we  = accept && (in_opcode == kwsm_pkg::OP_LEN)
                   && (int'(in_keyword_slot) < kwsm_pkg::MAX_KEYWORDS);

  // long lengths saturate, oversized counts clamp
  assign len_sat = kwsm_pkg::LEN_W'((int'(in_keyword_length) > kwsm_pkg::MAX_KEYWORD_LEN)
                   ? kwsm_pkg::MAX_KEYWORD_LEN : int'(in_keyword_length));
  assign active_eff = kwsm_pkg::KW_CNT_W'((int'(count_r) > kwsm_pkg::MAX_KEYWORDS)
                      ? kwsm_pkg::MAX_KEYWORDS : int'(count_r));

  // character store; the row at issue_r comes back in the following cycle
  kwsm_char_mem u_mem (
    .clk     (clk),
    .wr_en   (char_we),
    .wr_row  (kwsm_pkg::KW_IDX_W'(in_keyword_slot)),
    .wr_col  (kwsm_pkg::CHAR_IDX_W'(in_char_position)),
    .wr_data (in_byte_value),
    .rd_row  (issue_r[kwsm_pkg::KW_IDX_W-1:0]),
    .rd_data (row_data)
  );

  // shared compare and shift unit, one keyword row per cycle
  kwsm_row_unit u_row (
    .row       (row_data),
    .text_byte (byte_r),
    .len       (len_r[proc_idx_r]),
    .vec_in    (pv_r[proc_idx_r]),
    .res       (row_res)
  );

  // sequencer: issue rows 0..A-1, then finish the byte
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    issue_nxt     = issue_r;
    proc_v_nxt    = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    clear_pv      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == kwsm_pkg::OP_TEXT)) begin
          state_nxt  = ST_SCAN;
          active_nxt = active_eff;
          issue_nxt  = '0;
          byte_nxt   = in_byte_value;
          last_nxt   = in_last_byte;
        end
      end
      ST_SCAN: begin
        if (issue_r < active_r) begin
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = issue_r[kwsm_pkg::KW_IDX_W-1:0];
          issue_nxt    = kwsm_pkg::KW_CNT_W'(issue_r + 1'b1);
        end
        if (proc_v_r && row_res.hit) begin
          found_nxt = 1'b1;
        end
        // all rows issued and the last one folded in
        if ((issue_r == active_r) && !proc_v_r) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = found_r;
            found_nxt     = 1'b0;
            clear_pv      = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      issue_r     <= '0;
      proc_v_r    <= 1'b0;
      proc_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      issue_r     <= issue_nxt;
      proc_v_r    <= proc_v_nxt;
      proc_idx_r  <= proc_idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    out_found_r <= out_found_nxt;
  end

  // length table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < kwsm_pkg::MAX_KEYWORDS; k++) begin
        len_r[k] <= '0;
      end
    end else if (len_we) begin
      len_r[kwsm_pkg::KW_IDX_W'(in_keyword_slot)] <= len_sat;
    end
  end

  // prefix vectors: whole set clears at the end of a text
  always_ff @(posedge clk) begin
    if (!rst_n || clear_pv) begin
      for (int k = 0; k < kwsm_pkg::MAX_KEYWORDS; k++) begin
        pv_r[k] <= '0;
      end
    end else if (proc_v_r && row_res.upd) begin
      pv_r[proc_idx_r] <= row_res.vec;
    end
  end

  // a result only ever comes out with the block back at idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while scanning");

  // the found flag is cleared together with the result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !found_r)
    else $error("found flag not cleared after result");

  // row issue never runs past the active keyword count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_r <= active_r))
    else $error("row issue beyond active count");

  // a row in compare always belongs to an active keyword of the current byte
  assert property (@(posedge clk) disable iff (!rst_n)
    proc_v_r |-> ((state_r == ST_SCAN)
                  && (kwsm_pkg::KW_CNT_W'(proc_idx_r) < active_r)))
    else $error("row compare outside scan");

endmodule

FILE: verif/multi_keyword_substring_match_core_test.sv
module multi_keyword_substring_match_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kwsm_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  // covers the slowest text byte, with every keyword active, plus margin
  localparam int SETTLE_CYCLES = MAX_KEYWORDS + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;

  // opcode 3 has no meaning and must be dropped by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] slot;
    logic [4:0] position;
    logic [7:0] byte_val;
    logic [5:0] length;
    logic       last;
  } kw_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_keyword_slot = '0;
  logic [4:0] in_char_position = '0;
  logic [7:0] in_byte_value = '0;
  logic [5:0] in_keyword_length = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_found;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  multi_keyword_substring_match_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_keyword_slot  (in_keyword_slot),
    .in_char_position (in_char_position),
    .in_byte_value    (in_byte_value),
    .in_keyword_length(in_keyword_length),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // shadow copy of the keyword table and the scan state
  logic [7:0]           kw_char_mdl [MAX_KEYWORDS][MAX_KEYWORD_LEN];
  prefix_t              kw_written  [MAX_KEYWORDS];
  logic [LEN_W-1:0]     kw_len_mdl  [MAX_KEYWORDS];
  prefix_t              prefix_mdl  [MAX_KEYWORDS];
  logic                 found_mdl;
  logic [4:0]           count_mdl;

  // found values still owed by the block, oldest first
  logic                 found_expected_q [$];

  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          idle_pct = 0;   // chance of a sender gap before an item
  logic                 want_found;

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("mismatch: %s", msg);
  endfunction

  function automatic void clear_table_model();
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      for (int j = 0; j < MAX_KEYWORD_LEN; j++)
        kw_char_mdl[k][j] = '0;
      kw_written[k] = '0;
      kw_len_mdl[k] = '0;
      prefix_mdl[k] = '0;
    end
    found_mdl = 1'b0;
    count_mdl = '0;
  endfunction

  function automatic prefix_t len_mask(int unsigned n);
    if (n >= MAX_KEYWORD_LEN)
      return '1;
    return prefix_t'((64'd1 << n) - 64'd1);
  endfunction

  function automatic int unsigned active_slots();
    return (count_mdl > MAX_KEYWORDS) ? MAX_KEYWORDS : int'(count_mdl);
  endfunction

  // table write, or shift-and update of every active keyword, for one accepted item
  function automatic void scan_item(kw_item_t it);
    int unsigned n;
    prefix_t hits;
    case (it.opcode)
      OP_CHAR: begin
        if (it.slot < MAX_KEYWORDS && it.position < MAX_KEYWORD_LEN) begin
          kw_char_mdl[it.slot][it.position] = it.byte_val;
          kw_written[it.slot][it.position] = 1'b1;
        end
      end
      OP_LEN: begin
        if (it.slot < MAX_KEYWORDS)
          kw_len_mdl[it.slot] = (it.length > MAX_KEYWORD_LEN) ? LEN_W'(MAX_KEYWORD_LEN)
                                                              : it.length;
      end
      OP_TEXT: begin
        for (int k = 0; k < active_slots(); k++) begin
          n = kw_len_mdl[k];
          if (n == 0) begin
            // empty keyword matches any text
            found_mdl = 1'b1;
          end else begin
            hits = '0;
            for (int j = 0; j < n; j++)
              if (kw_char_mdl[k][j] == it.byte_val)
                hits[j] = 1'b1;
            prefix_mdl[k] = ((prefix_mdl[k] << 1) | prefix_t'(1)) & hits & len_mask(n);
            if (prefix_mdl[k][n-1])
              found_mdl = 1'b1;
          end
        end
        if (it.last) begin
          found_expected_q.push_back(found_mdl);
          for (int k = 0; k < MAX_KEYWORDS; k++)
            prefix_mdl[k] = '0;
          found_mdl = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(kw_item_t it);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(3, 0) == 0)
        repeat ($urandom_range(20, 1)) @(posedge clk);
      else
        repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start             <= 1'b1;
    in_opcode         <= it.opcode;
    in_keyword_slot   <= it.slot;
    in_char_position  <= it.position;
    in_byte_value     <= it.byte_val;
    in_keyword_length <= it.length;
    in_last_byte      <= it.last;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    scan_item(it);
    items_sent++;
  endtask

  // unused fields carry random values so their bits move too
  task automatic send_char(int unsigned slot, int unsigned pos, logic [7:0] val);
    kw_item_t it;
    it.opcode   = OP_CHAR;
    it.slot     = 4'(slot);
    it.position = 5'(pos);
    it.byte_val = val;
    it.length   = 6'($urandom);
    it.last     = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_len(int unsigned slot, int unsigned len);
    kw_item_t it;
    it.opcode   = OP_LEN;
    it.slot     = 4'(slot);
    it.position = 5'($urandom);
    it.byte_val = 8'($urandom);
    it.length   = 6'(len);
    it.last     = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_text(logic [7:0] val, logic last);
    kw_item_t it;
    it.opcode   = OP_TEXT;
    it.slot     = 4'($urandom);
    it.position = 5'($urandom);
    it.byte_val = val;
    it.length   = 6'($urandom);
    it.last     = last;
    send_item(it);
  endtask

  task automatic send_unused();
    kw_item_t it;
    it.opcode   = OP_UNUSED;
    it.slot     = 4'($urandom);
    it.position = 5'($urandom);
    it.byte_val = 8'($urandom);
    it.length   = 6'($urandom);
    it.last     = 1'($urandom);
    send_item(it);
  endtask

  function automatic logic [7:0] pick_char(logic [7:0] base, int unsigned size);
    if (size >= 256)
      return 8'($urandom);
    return base + 8'($urandom_range(size - 1, 0));
  endfunction

  // a length is only set once every character it covers has been written,
  // so the block never compares an unwritten entry inside a keyword's length
  task automatic set_len_filled(int unsigned slot, int unsigned len, logic [7:0] base,
                                int unsigned size);
    int unsigned eff;
    eff = (len > MAX_KEYWORD_LEN) ? MAX_KEYWORD_LEN : len;
    for (int p = 0; p < eff; p++)
      if (!kw_written[slot][p])
        send_char(slot, p, pick_char(base, size));
    send_len(slot, len);
  endtask

  // block quiet: no result owed, busy low, and the longest scan drained
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (found_expected_q.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_keyword_count(int unsigned value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 5'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    count_mdl = 5'(value);
  endtask

  // each result is checked against the oldest owed value
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (found_expected_q.size() == 0) begin
        note_failure($sformatf("result found=%0b with none expected", out_found));
      end else begin
        want_found = found_expected_q.pop_front();
        if (out_found !== want_found)
          note_failure($sformatf("found expected %0b actual %0b", want_found, out_found));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL multi_keyword_substring_match_core");
      $finish;
    end
  end

  // no keywords active after reset: nothing can match, opcode 3 dropped
  task automatic test_empty_table();
    send_text(8'h41, 1'b1);
    send_unused();
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
  endtask

  // slot 0 still has length zero, so the empty keyword matches
  task automatic test_zero_length();
    set_keyword_count(1);
    send_text(8'h5A, 1'b1);
  endtask

  // extreme byte values as keyword and text characters
  task automatic test_byte_extremes();
    send_char(0, 0, 8'h00);
    send_char(0, 1, 8'hFF);
    send_len(0, 2);
    send_char(15, 31, 8'hFF);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
  endtask

  // count and table changed while a text is open
  task automatic test_midtext_changes();
    send_char(1, 0, 8'h63);
    send_char(1, 1, 8'h64);
    send_len(1, 2);
    set_keyword_count(2);
    send_text(8'h63, 1'b0);
    // slot 1 drops out but keeps its partial prefix
    set_keyword_count(1);
    send_text(8'h78, 1'b0);
    set_keyword_count(2);
    send_text(8'h64, 1'b1);
    // new character takes effect from the next text byte on
    send_text(8'h00, 1'b0);
    send_char(0, 1, 8'h77);
    send_text(8'h77, 1'b1);
  endtask

  // counts above the table size act as the table size
  task automatic test_count_clamp();
    set_keyword_count(31);
    send_text(8'h01, 1'b1);
    set_keyword_count(MAX_KEYWORDS);
    send_text(8'h02, 1'b1);
  endtask

  // full-length keyword, and length values past the limit saturate
  task automatic test_long_keyword();
    logic [7:0] word [MAX_KEYWORD_LEN];
    for (int p = 0; p < MAX_KEYWORD_LEN; p++) begin
      // upper half only, away from the other keywords
      word[p] = 8'h80 | 8'($urandom);
      send_char(2, p, word[p]);
    end
    send_len(2, 63);
    set_keyword_count(3);
    for (int p = 0; p < MAX_KEYWORD_LEN; p++)
      send_text(word[p], p == MAX_KEYWORD_LEN - 1);
    send_len(2, 33);
    for (int p = 0; p < MAX_KEYWORD_LEN - 1; p++)
      send_text(word[p], 1'b0);
    send_text(8'h10, 1'b1);
    send_len(2, MAX_KEYWORD_LEN);
    for (int p = 0; p < MAX_KEYWORD_LEN; p++)
      send_text(word[p], p == MAX_KEYWORD_LEN - 1);
  endtask

  task automatic load_random_keyword(logic [7:0] base, int unsigned size);
    int unsigned slot;
    int unsigned eff;
    int unsigned len;
    int unsigned r;
    if (active_slots() > 0 && $urandom_range(4, 0) != 0)
      slot = $urandom_range(active_slots() - 1, 0);
    else
      slot = $urandom_range(MAX_KEYWORDS - 1, 0);
    r = $urandom_range(19, 0);
    if (r == 0)
      eff = 0;
    else if (r == 1)
      eff = $urandom_range(MAX_KEYWORD_LEN, 5);
    else
      eff = $urandom_range(4, 1);
    len = (eff == MAX_KEYWORD_LEN && $urandom_range(1, 0) == 1) ? $urandom_range(63, 33) : eff;
    for (int p = 0; p < eff; p++)
      send_char(slot, p, pick_char(base, size));
    send_len(slot, len);
  endtask

  // noise inside a text: table writes and dropped opcodes
  task automatic send_noise(logic [7:0] base, int unsigned size);
    case ($urandom_range(2, 0))
      0: send_char($urandom_range(MAX_KEYWORDS - 1, 0), $urandom_range(MAX_KEYWORD_LEN - 1, 0),
                   pick_char(base, size));
      1: set_len_filled($urandom_range(MAX_KEYWORDS - 1, 0), $urandom_range(6, 0), base, size);
      default: send_unused();
    endcase
  endtask

  task automatic send_random_text(logic [7:0] base, int unsigned size);
    logic [7:0]  txt [64];
    int unsigned n;
    int unsigned k;
    int unsigned klen;
    int unsigned at;
    logic        hold_open;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
    klen = 0;
    if (active_slots() > 0 && $urandom_range(1, 0) == 1) begin
      k = $urandom_range(active_slots() - 1, 0);
      klen = kw_len_mdl[k];
      if (klen > n)
        n = klen;
    end
    for (int i = 0; i < n; i++)
      txt[i] = pick_char(base, size);
    // plant a stored keyword somewhere in the text
    if (klen > 0) begin
      at = $urandom_range(n - klen, 0);
      for (int j = 0; j < klen; j++)
        txt[at + j] = kw_char_mdl[k][j];
    end
    // now and then the text runs on into the next round
    hold_open = ($urandom_range(9, 0) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19, 0) == 0)
        send_noise(base, size);
      send_text(txt[i], (i == n - 1) && !hold_open);
    end
  endtask

  task automatic test_random_texts(int unsigned budget);
    int unsigned first;
    int unsigned r;
    int unsigned size;
    logic [7:0]  base;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(3, 0) == 0) begin
        r = $urandom_range(9, 0);
        if (r == 0)
          set_keyword_count(0);
        else if (r == 1)
          set_keyword_count(MAX_KEYWORDS);
        else if (r == 2)
          set_keyword_count($urandom_range(31, MAX_KEYWORDS + 1));
        else
          set_keyword_count($urandom_range(4, 1));
      end
      base = 8'($urandom);
      size = ($urandom_range(9, 0) < 7) ? $urandom_range(3, 2) : 256;
      repeat ($urandom_range(2, 0)) load_random_keyword(base, size);
      send_random_text(base, size);
    end
  endtask

  initial begin
    clear_table_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_zero_length();
    test_byte_extremes();
    test_midtext_changes();
    test_count_clamp();
    test_long_keyword();

    // back to back items, then sender gaps; results cannot be held off
    idle_pct = 0;
    test_random_texts(400);
    idle_pct = 47;
    test_random_texts(400);
    idle_pct = 10;
    test_random_texts(400);

    wait_idle();
    if (error_count == 0)
      $display("PASS multi_keyword_substring_match_core");
    else
      $display("FAIL multi_keyword_substring_match_core");
    $finish;
  end

endmodule
